// ===== hw/rtl/ols_pkg.sv =====
// Shared types, sizes and the address helper for the ordered list store.
// Used by ols_ctrl and ordered_list_store; no dependencies.
package ols_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        REQ_APPEND    = 2'd0,
        REQ_POP_FRONT = 2'd1,
        REQ_POP_REAR  = 2'd2,
        REQ_INSERT    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_READ
    } state_t;

    // one access pair for the entry RAM
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // result beat handed from the controller to the output register
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [DATA_W-1:0] removed;
        logic [LEN_W-1:0]  length;
    } res_t;

    // logical index -> physical RAM address (circular, front at head)
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0]  idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

// ===== hw/rtl/ordered_list_store.sv =====
// Top level of the ordered list store: sequencer, entry RAM, result register.
// Depends on ols_pkg, ols_ctrl and ols_ram.
//
// Bounded list of signed 32-bit values, front first, up to CAPACITY entries.
// Request channel: req_type, item_value and position are taken at a rising
// edge with start high and busy low. Result channel: done is high for one
// cycle with status, removed_value and list_length; there is no back-pressure,
// the receiver must take the beat in that cycle.
// Request timing:
//   append, rejected request, insert at the rear: done in the next cycle,
//     busy stays low, so a request can be issued every cycle.
//   remove front / remove rear: one RAM read in S_READ, then done from the result register.
//   positional insert: S_SHIFT moves every entry from the slot to the rear up
//     by one, then S_PLACE writes the item; the single RAM write port moves one entry per cycle.
// Front removal moves a head pointer in a circular RAM, so it never walks.
// The result register lets a new request be accepted in the cycle its
// predecessor's result is on the ports.
// Reset clears length, head and state; RAM contents are not cleared, only
// entries written since are ever read, so no clearing pass is needed.
module ordered_list_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic signed [ols_pkg::DATA_W-1:0]  item_value,
    input  logic [ols_pkg::POS_W-1:0]          position,
    output logic                               done,
    output logic [2:0]                         status,
    output logic signed [ols_pkg::DATA_W-1:0]  removed_value,
    output logic [ols_pkg::LEN_W-1:0]          list_length
);
    import ols_pkg::*;

    mem_req_t            mem;
    logic [DATA_W-1:0]   rdata;
    res_t                res;

    logic                done_reg;
    status_t             status_reg;
    logic [DATA_W-1:0]   removed_reg;
    logic [LEN_W-1:0]    length_reg;

    ols_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .item_value (item_value),
        .position   (position),
        .mem        (mem),
        .rdata      (rdata),
        .res        (res)
    );

    // entry store: written by appends, inserts and shifts, read for removals and shifts
    ols_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg  <= res.status;
            removed_reg <= res.removed;
            length_reg  <= res.length;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign list_length   = length_reg;

`ifndef NO_ASSERTIONS
    // only a successful removal carries a value
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (removed_value == '0))
        else $error("removed_value nonzero on a failed request");

    // an empty report means the list really is empty
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> (list_length == '0))
        else $error("empty status with nonzero length");

    // a full report means the list is at capacity
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) |-> (list_length == LEN_W'(CAPACITY)))
        else $error("full status below capacity");

    // a multi-cycle request never produces a result while still working
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !res.valid |=> !done)
        else $error("result strobed during shift");
`endif

endmodule

// ===== hw/rtl/ols_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module ols_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ols_ctrl.sv =====
// Request sequencer: decodes requests, walks the entry RAM for shifts,
// keeps length and head pointer. Depends on ols_pkg.
module ols_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      req_type,
    input  logic [ols_pkg::DATA_W-1:0]      item_value,
    input  logic [ols_pkg::POS_W-1:0]       position,
    output ols_pkg::mem_req_t               mem,
    input  logic [ols_pkg::DATA_W-1:0]      rdata,
    output ols_pkg::res_t                   res
);
    import ols_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   slot_reg, slot_next;
    logic [DATA_W-1:0]  value_reg, value_next;

    logic               full, empty;
    logic [CNT_W-1:0]   slot_in;

    assign full    = (count_reg >= CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign slot_in = CNT_W'(CMP_W'(position) - CMP_W'(1));
    assign busy    = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        value_next  = value_reg;
        mem         = '0;
        res.valid   = 1'b0;
        res.status  = ST_OK;
        res.removed = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res.valid = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_APPEND:
                        begin
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem.we     = 1'b1;
                                mem.waddr  = phys_addr(head_reg, count_reg);
                                mem.wdata  = item_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                // front leaves by moving head, no shift
                                res.valid  = 1'b0;
                                mem.raddr  = head_reg;
                                head_next  = phys_addr(head_reg, CNT_W'(1));
                                count_next = count_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        REQ_POP_REAR:
                        begin
                            if (empty)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                res.valid  = 1'b0;
                                mem.raddr  = phys_addr(head_reg, count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else if (position == '0)
                            begin
                                res.status = ST_INVALID;
                            end
                            else if (CMP_W'(position) > CMP_W'(count_reg) + CMP_W'(1))
                            begin
                                res.status = ST_RANGE;
                            end
                            else if (slot_in == count_reg)
                            begin
                                // insert just behind the rear: plain append
                                mem.we     = 1'b1;
                                mem.waddr  = phys_addr(head_reg, count_reg);
                                mem.wdata  = item_value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res.valid  = 1'b0;
                                value_next = item_value;
                                slot_next  = slot_in;
                                idx_next   = count_reg;
                                mem.raddr  = phys_addr(head_reg, count_reg - 1'b1);
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            res.valid = 1'b0;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // rdata holds entry idx-1; move it up one, prefetch idx-2
                mem.we    = 1'b1;
                mem.waddr = phys_addr(head_reg, idx_reg);
                mem.wdata = rdata;
                if ((idx_reg - 1'b1) == slot_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mem.raddr = phys_addr(head_reg, idx_reg - CNT_W'(2));
                    idx_next  = idx_reg - 1'b1;
                end
            end

            S_PLACE:
            begin
                mem.we     = 1'b1;
                mem.waddr  = phys_addr(head_reg, slot_reg);
                mem.wdata  = value_reg;
                count_next = count_reg + 1'b1;
                res.valid  = 1'b1;
                state_next = S_IDLE;
            end

            S_READ:
            begin
                res.valid   = 1'b1;
                res.removed = rdata;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.length = LEN_W'(count_next);
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for ordered_list_store: directed list edge cases, then
// random fill/drain phases. Depends on ols_pkg and the ordered_list_store RTL.
`timescale 1ns / 1ps

module testbench;
    import ols_pkg::*;

    // one expected result beat
    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] removed;
        logic [LEN_W-1:0]         length;
    } list_outcome_t;

    // Shadow copy of the list plus the FIFO of outcomes still owed by the DUT.
    // A SV queue holds the list front first, so every successful request maps onto one
    // queue operation.
    class list_tracker;
        logic signed [DATA_W-1:0] shadow_list[$];
        list_outcome_t            owed_results[$];
        int                       errors = 0;

        // apply one accepted request to the shadow list, queue its outcome
        function void note_request(req_t kind, logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            list_outcome_t o;
            o.status  = ST_OK;
            o.removed = '0;
            case (kind)
                REQ_APPEND:
                begin
                    if (shadow_list.size() >= CAPACITY)
                        o.status = ST_FULL;
                    else
                        shadow_list.push_back(value);
                end
                REQ_POP_FRONT:
                begin
                    if (shadow_list.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        o.removed = shadow_list.pop_front();
                end
                REQ_POP_REAR:
                begin
                    if (shadow_list.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        o.removed = shadow_list.pop_back();
                end
                default:
                begin
                    // full wins over a bad position
                    if (shadow_list.size() >= CAPACITY)
                        o.status = ST_FULL;
                    else if (pos == '0)
                        o.status = ST_INVALID;
                    else if (int'(pos) > shadow_list.size() + 1)
                        o.status = ST_RANGE;
                    else
                        shadow_list.insert(int'(pos) - 1, value);
                end
            endcase
            o.length = LEN_W'(shadow_list.size());
            owed_results.push_back(o);
        endfunction

        // compare one result beat with the oldest owed outcome
        function void check_result(status_t st, logic signed [DATA_W-1:0] rem,
                                   logic [LEN_W-1:0] len);
            list_outcome_t w;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, status %0d removed %0d length %0d",
                         $time, st, rem, len);
                errors++;
                return;
            end
            w = owed_results.pop_front();
            if (st !== w.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, w.status, st);
                errors++;
            end
            if (rem !== w.removed)
            begin
                $display("%0t: removed_value mismatch, expected %0d actual %0d",
                         $time, w.removed, rem);
                errors++;
            end
            if (len !== w.length)
            begin
                $display("%0t: list_length mismatch, expected %0d actual %0d",
                         $time, w.length, len);
                errors++;
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        function int depth();
            return shadow_list.size();
        endfunction
    endclass

    // worst item: insert at front of a near-full list plus the longest sender
    // gap; the limit leaves several times headroom over the whole run
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 600;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [1:0]                 req_type = REQ_APPEND;
    logic signed [DATA_W-1:0]   item_value = '0;
    logic [POS_W-1:0]           position = '0;
    logic                       busy;
    logic                       done;
    logic [2:0]                 status;
    logic signed [DATA_W-1:0]   removed_value;
    logic [LEN_W-1:0]           list_length;

    int          cycle_count = 0;
    bit          no_gaps = 1'b0;
    list_tracker tracker = new();

    ordered_list_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .item_value    (item_value),
        .position      (position),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .list_length   (list_length)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Result side: done is a one-cycle strobe, no back-pressure, so every
    // edge with done high is a beat to check.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(status_t'(status), removed_value, list_length);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive one request and hold it until the DUT takes it (start high, busy
    // low at an edge). Start is left high so a back-to-back request does not
    // drop it; the gap task lowers it when there is idle time.
    task automatic send_request(req_t kind, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
        start      <= 1'b1;
        req_type   <= kind;
        item_value <= value;
        position   <= pos;
        do
            @(posedge clk);
        while (busy);
        tracker.note_request(kind, value, pos);
    endtask

    // random sender idle time: mostly none or short, occasionally long
    task automatic sender_gap();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            len = 0;
        else if (r < 88)
            len = $urandom_range(1, 3);
        else if (r < 97)
            len = $urandom_range(4, 12);
        else
            len = $urandom_range(20, 60);
        if (len > 0)
        begin
            start <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // hold off until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.owed() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // insert position: mostly legal, some zero, some past the rear
    function automatic logic [POS_W-1:0] pick_position(int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
            return POS_W'($urandom_range(1, len + 1));
        else if (r < 84)
            return '0;
        else
            return POS_W'($urandom_range(len + 2, 255));
    endfunction

    initial
    begin
        bit   growing;
        int   full_hits;
        int   empty_hits;
        int   r;
        req_t kind;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list rejects, bad positions, value extremes,
        // front/middle/rear inserts, both removals, then drain
        no_gaps = 1'b1;
        send_request(REQ_POP_FRONT, 32'sh1234_5678, 8'd0);
        send_request(REQ_POP_REAR, -1, 8'd255);
        send_request(REQ_INSERT, 32'sd7, 8'd0);           // invalid position
        send_request(REQ_INSERT, 32'sd7, 8'd2);           // past rear on empty
        send_request(REQ_INSERT, 32'sh8000_0000, 8'd1);   // front of empty list
        send_request(REQ_APPEND, 32'sh7FFF_FFFF, 8'd0);
        send_request(REQ_INSERT, -1, 8'd3);               // just behind rear
        send_request(REQ_INSERT, 32'sd0, 8'd2);           // middle
        send_request(REQ_INSERT, 32'sh5555_5555, 8'd1);   // front
        wait_drained();
        send_request(REQ_INSERT, 32'sd9, 8'd255);         // far out of range
        send_request(REQ_INSERT, 32'sd9, 8'd0);
        send_request(REQ_INSERT, 32'sd9, 8'd7);           // length + 2
        send_request(REQ_POP_FRONT, 32'sd0, 8'd0);
        send_request(REQ_POP_REAR, 32'sd0, 8'd0);
        send_request(REQ_INSERT, 32'shAAAA_AAAA, 8'd128); // out of range
        send_request(REQ_APPEND, 32'shAAAA_AAAA, 8'd255);
        no_gaps = 1'b0;
        repeat (5)
        begin
            send_request(REQ_POP_FRONT, $urandom, POS_W'($urandom));
            sender_gap();
        end
        wait_drained();

        // random: alternate fill and drain phases so full and empty are both
        // hit repeatedly; a phase flips after a few beats at the boundary
        growing    = 1'b1;
        full_hits  = 0;
        empty_hits = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if ((growing && r < 80) || (!growing && r >= 80))
                kind = ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_INSERT;
            else
                kind = ($urandom_range(0, 1) == 0) ? REQ_POP_FRONT : REQ_POP_REAR;
            send_request(kind, pick_value(), pick_position(tracker.depth()));

            if (growing && tracker.depth() == CAPACITY && ++full_hits >= 4)
            begin
                growing   = 1'b0;
                full_hits = 0;
                wait_drained();
            end
            else if (!growing && tracker.depth() == 0 && ++empty_hits >= 3)
            begin
                growing    = 1'b1;
                empty_hits = 0;
                wait_drained();
            end
            else
                sender_gap();
        end

        start <= 1'b0;
        while (tracker.owed() != 0)
            @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (CAPACITY + 8) @(posedge clk);

        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
